@@ sv/dfph_pkg.sv @@
package dfph_pkg;

  localparam int CharW  = 8;
  localparam int AccW   = 11;
  localparam int WordW  = 32;
  localparam int PosW   = 3;
  localparam int FieldW = 3;
  localparam int CountW = 4;

  // byte positions inside a field and fields inside a record
  localparam logic [PosW-1:0]   PosSign   = 3'd0;
  localparam logic [PosW-1:0]   PosSep    = 3'd5;
  localparam logic [FieldW-1:0] FieldLast = 3'd4;

  // ascii codes
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChNl    = 8'h0a;

  // output sequence: "0x", eight hex digits, newline
  localparam logic [CountW-1:0] CntZero   = 4'd0;
  localparam logic [CountW-1:0] CntX      = 4'd1;
  localparam logic [CountW-1:0] CntNl     = 4'd10;
  localparam logic [CountW-1:0] CntDigHi  = 4'd9;

  // finished word handed to the text emitter
  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] word;
  } load_t;

  // mask a field value and place it at its offset in the word
  function automatic logic [WordW-1:0] field_bits(input logic [FieldW-1:0] idx,
                                                  input logic [AccW-1:0] val);
    logic [WordW-1:0] ext;
    ext = {{(WordW-AccW){1'b0}}, val};
    case (idx)
      3'd0:    field_bits = (ext & 32'h0000_0007);
      3'd1:    field_bits = (ext & 32'h0000_00ff) << 3;
      3'd2:    field_bits = (ext & 32'h0000_001f) << 11;
      3'd3:    field_bits = (ext & 32'h0000_001f) << 16;
      3'd4:    field_bits = (ext & 32'h0000_07ff) << 21;
      default: field_bits = (ext & 32'h0000_0007);
    endcase
  endfunction

  // uppercase hex digit of a nibble
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    if (nib >= 4'd10) hex_char = ChUpA + {4'd0, nib} - 8'd10;
    else hex_char = ChZero + {4'd0, nib};
  endfunction

endpackage

@@ sv/dfph_emit.sv @@
module dfph_emit (
  input  logic            clk,
  input  logic            rst,
  input  dfph_pkg::load_t load,
  output logic            ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tlast    // out_last
);
  import dfph_pkg::*;

  logic              busy;
  logic [CountW-1:0] count;
  logic [WordW-1:0]  word;
  logic              xfer;
  logic [3:0]        nib;
  logic [CountW-1:0] nib_sel;

  assign xfer  = m_tvalid && m_tready;
  assign ready = !busy || (xfer && count == CntNl);

  // sequence counter and held word
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= CntZero;
    end else begin
      if (load.valid) begin
        busy  <= 1'b1;
        count <= CntZero;
        word  <= load.word;
      end else if (xfer) begin
        if (count == CntNl) begin
          busy  <= 1'b0;
          count <= CntZero;
        end else begin
          count <= count + 4'd1;
        end
      end
    end
  end

  // nibble select, most significant first
  assign nib_sel = CntDigHi - count;
  always_comb begin
    case (nib_sel)
      4'd0:    nib = word[3:0];
      4'd1:    nib = word[7:4];
      4'd2:    nib = word[11:8];
      4'd3:    nib = word[15:12];
      4'd4:    nib = word[19:16];
      4'd5:    nib = word[23:20];
      4'd6:    nib = word[27:24];
      4'd7:    nib = word[31:28];
      default: nib = 4'd0;
    endcase
  end

  // output character
  always_comb begin
    case (count)
      CntZero: m_tdata = ChZero;
      CntX:    m_tdata = ChX;
      CntNl:   m_tdata = ChNl;
      default: m_tdata = hex_char(nib);
    endcase
  end

  assign m_tvalid = busy;
  assign m_tlast  = busy && count == CntNl;

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> count == CntZero) else $error("count not cleared while idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> ready) else $error("word loaded while text still pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> count <= CntNl) else $error("sequence count out of range");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (xfer && m_tlast && !load.valid) |=> !busy) else $error("emitter stuck busy");

endmodule

@@ sv/decimal_fields_to_packed_hex.sv @@
// channel | dir | tdata               | other
// s_      | in  | [7:0] in_char       | -
// m_      | out | [7:0] out_char      | tlast = out_last
//
// one input byte is taken per cycle while s_tready is high; the 30th byte of a record
// hands the packed word to the text emitter, which sends 11 bytes at one per cycle
// while m_tready is high. s_tready drops only on a record's final byte while the
// previous record's text has not fully left; output stalls hold m_tdata and m_tlast.
// rst is synchronous and clears the field position, sign, accumulator and word.
module decimal_fields_to_packed_hex (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // out_last
);
  import dfph_pkg::*;

  logic [PosW-1:0]   char_position;
  logic [FieldW-1:0] field_index;
  logic              negative_flag;
  logic [AccW-1:0]   digit_accumulator;
  logic [WordW-1:0]  packed_word;

  logic              accept;
  logic              rec_end;
  logic              emit_ready;
  logic [AccW-1:0]   digit;
  logic [AccW-1:0]   acc_next;
  logic [AccW-1:0]   val;
  logic [WordW-1:0]  word_next;
  load_t             load;

  assign rec_end  = char_position == PosSep && field_index == FieldLast;
  assign s_tready = !rec_end || emit_ready;
  assign accept   = s_tvalid && s_tready;

  // digit update: acc * 10 + (byte - '0'), modulo 2048
  assign digit    = {3'd0, s_tdata} - {3'd0, ChZero};
  assign acc_next = (digit_accumulator << 3) + (digit_accumulator << 1) + digit;

  // signed field value and the word with it merged in
  assign val       = negative_flag ? (11'd0 - digit_accumulator) : digit_accumulator;
  assign word_next = packed_word | field_bits(field_index, val);

  // field parser
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= PosSign;
      field_index       <= 3'd0;
      negative_flag     <= 1'b0;
      digit_accumulator <= '0;
      packed_word       <= '0;
    end else if (accept) begin
      if (char_position == PosSign) begin
        negative_flag     <= s_tdata == ChMinus;
        digit_accumulator <= '0;
        char_position     <= char_position + 3'd1;
      end else if (char_position != PosSep) begin
        digit_accumulator <= acc_next;
        char_position     <= char_position + 3'd1;
      end else begin
        char_position <= PosSign;
        if (field_index == FieldLast) begin
          field_index <= 3'd0;
          packed_word <= '0;
        end else begin
          field_index <= field_index + 3'd1;
          packed_word <= word_next;
        end
      end
    end
  end

  assign load.valid = accept && rec_end;
  assign load.word  = word_next;

  dfph_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ready    (emit_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    char_position <= PosSep) else $error("char position out of range");

  a_field_range: assert property (@(posedge clk) disable iff (rst)
    field_index <= FieldLast) else $error("field index out of range");

  a_word_clear: assert property (@(posedge clk) disable iff (rst)
    load.valid |=> packed_word == '0) else $error("word not cleared after record");

endmodule
